### rtl/lcbt_pkg.sv
// Shared types, codes and constants of the logical channel buffer table.
// No dependencies; used by every module of the block.
package lcbt_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 32;
  localparam int unsigned TOTAL_W = 34;
  localparam int unsigned LC_ID_W = 5;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [31:0] OH_DL_CH1 = 32'd4;
  localparam logic [31:0] OH_DEFAULT = 32'd2;
  localparam logic [31:0] FLOOR_UL = 32'd12;
  localparam logic [31:0] FLOOR_DL = 32'd10;
  localparam logic [LC_ID_W-1:0] OH_LC_ID = 5'd1;

  typedef enum logic [2:0] {
    MODE_INSERT       = 3'd0,
    MODE_BUF_REPORT   = 3'd1,
    MODE_GROUP_REPORT = 3'd2,
    MODE_GRANT        = 3'd3,
    MODE_RELEASE      = 3'd4,
    MODE_QUERY        = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_ABSENT  = 3'd1,
    ERR_PRESENT = 3'd2,
    ERR_UNUSED  = 3'd3,
    ERR_GROUP   = 3'd4
  } err_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [LC_ID_W-1:0] lc_id;
    logic [31:0]        tx_queue_bytes;
    logic [31:0]        retx_queue_bytes;
    logic [31:0]        status_bytes;
    logic [31:0]        grant_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic        lc_present;
    logic [31:0] lc_total_bytes;
    logic [31:0] group_total_bytes;
    logic [31:0] active_mask;
    logic [5:0]  channel_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] status;
    logic [31:0] retx;
    logic [31:0] tx;
  } entry_t;

  // what one item does to the table
  typedef struct packed {
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } upd_ctl_t;

  function automatic logic [TOTAL_W-1:0] entry_total(entry_t e);
    return TOTAL_W'(e.status) + TOTAL_W'(e.retx) + TOTAL_W'(e.tx);
  endfunction

  function automatic logic [31:0] sat32(logic [TOTAL_W-1:0] v);
    return (v > TOTAL_W'(MAX32)) ? MAX32 : v[31:0];
  endfunction

endpackage

### rtl/lcbt_update.sv
// Per-item decision logic: error code, table action and new entry contents.
// Depends on lcbt_pkg.
module lcbt_update (
  input  lcbt_pkg::in_item_t in_item_i,
  input  lcbt_pkg::entry_t   old_i,
  input  logic               inr_i,
  input  logic               here_i,
  input  logic               count_one_i,
  input  logic               uplink_i,
  output lcbt_pkg::upd_ctl_t ctl_o,
  output lcbt_pkg::err_e     err_o,
  output lcbt_pkg::entry_t   new_o
);

  logic [31:0] oh;
  logic [31:0] net;
  logic [31:0] tx_left;
  logic [31:0] floor_val;
  logic [31:0] g;

  always_comb begin
    g         = in_item_i.grant_bytes;
    oh        = (in_item_i.lc_id == lcbt_pkg::OH_LC_ID && !uplink_i) ?
                lcbt_pkg::OH_DL_CH1 : lcbt_pkg::OH_DEFAULT;
    net       = (g >= oh) ? (g - oh) : 32'd0;
    tx_left   = (net >= old_i.tx) ? 32'd0 : (old_i.tx - net);
    floor_val = uplink_i ? lcbt_pkg::FLOOR_UL : lcbt_pkg::FLOOR_DL;
    if (tx_left != 32'd0 && tx_left < floor_val) begin
      tx_left = floor_val;
    end
  end

  always_comb begin
    ctl_o = '0;
    err_o = lcbt_pkg::ERR_OK;
    new_o = old_i;
    case (lcbt_pkg::mode_e'(in_item_i.mode))
      lcbt_pkg::MODE_INSERT: begin
        if (!inr_i) begin
          err_o = lcbt_pkg::ERR_ABSENT;
        end else if (here_i) begin
          err_o = lcbt_pkg::ERR_PRESENT;
        end else begin
          ctl_o.wr_en     = 1'b1;
          ctl_o.set_valid = 1'b1;
          new_o           = '0;
        end
      end
      lcbt_pkg::MODE_BUF_REPORT: begin
        if (!here_i) begin
          err_o = lcbt_pkg::ERR_ABSENT;
        end else begin
          ctl_o.wr_en  = 1'b1;
          new_o.status = in_item_i.status_bytes;
          new_o.retx   = in_item_i.retx_queue_bytes;
          new_o.tx     = in_item_i.tx_queue_bytes;
        end
      end
      lcbt_pkg::MODE_GROUP_REPORT: begin
        // old_i holds the single present channel here
        if (!count_one_i) begin
          err_o = lcbt_pkg::ERR_GROUP;
        end else begin
          ctl_o.wr_en = 1'b1;
          new_o.tx    = in_item_i.tx_queue_bytes;
        end
      end
      lcbt_pkg::MODE_GRANT: begin
        if (!here_i) begin
          err_o = lcbt_pkg::ERR_ABSENT;
        end else if (old_i.status != 32'd0 && g >= old_i.status) begin
          ctl_o.wr_en  = 1'b1;
          new_o.status = 32'd0;
        end else if (old_i.retx != 32'd0 && g >= old_i.retx) begin
          ctl_o.wr_en = 1'b1;
          new_o.retx  = 32'd0;
        end else if (old_i.tx != 32'd0) begin
          ctl_o.wr_en = 1'b1;
          new_o.tx    = tx_left;
        end else begin
          err_o = lcbt_pkg::ERR_UNUSED;
        end
      end
      lcbt_pkg::MODE_RELEASE: begin
        if (!here_i) begin
          err_o = lcbt_pkg::ERR_ABSENT;
        end else begin
          ctl_o.clr_valid = 1'b1;
        end
      end
      default: begin
        err_o = here_i ? lcbt_pkg::ERR_OK : lcbt_pkg::ERR_ABSENT;
      end
    endcase
  end

endmodule

### rtl/lcbt_table.sv
// Channel table: backlog memory with registered read and write bypass, valid
// bits, active mask, channel count and running group total. Depends on lcbt_pkg.
module lcbt_table #(
  parameter int unsigned NumChannels = lcbt_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1,
  parameter int unsigned CntW = $clog2(NumChannels + 1),
  parameter int unsigned GsumW = lcbt_pkg::TOTAL_W + $clog2(NumChannels)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_addr_i,
  input  logic                 commit_i,
  input  lcbt_pkg::upd_ctl_t   ctl_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  lcbt_pkg::entry_t     wr_data_i,
  output lcbt_pkg::entry_t     rd_data_o,
  output logic [NumChannels-1:0] valid_q_o,
  output logic [CntW-1:0]      count_q_o,
  output logic [NumChannels-1:0] valid_d_o,
  output logic [CntW-1:0]      count_d_o,
  output logic [NumChannels-1:0] mask_d_o,
  output logic [GsumW-1:0]     gsum_d_o
);

  lcbt_pkg::entry_t mem [NumChannels];
  lcbt_pkg::entry_t rd_q;

  logic [NumChannels-1:0] valid_q, valid_d;
  logic [NumChannels-1:0] mask_q, mask_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [GsumW-1:0]       gsum_q, gsum_d;

  logic                   old_valid, new_valid, change;
  lcbt_pkg::entry_t       new_data;
  logic [lcbt_pkg::TOTAL_W-1:0] old_t, new_t;

  always_comb begin
    old_valid = valid_q[wr_addr_i];
    new_valid = ctl_i.set_valid | (old_valid & ~ctl_i.clr_valid);
    new_data  = ctl_i.wr_en ? wr_data_i : rd_q;
    old_t     = old_valid ? lcbt_pkg::entry_total(rd_q) : '0;
    new_t     = new_valid ? lcbt_pkg::entry_total(new_data) : '0;
    change    = commit_i & (ctl_i.wr_en | ctl_i.set_valid | ctl_i.clr_valid);

    valid_d = valid_q;
    mask_d  = mask_q;
    count_d = count_q;
    gsum_d  = gsum_q;
    if (change) begin
      valid_d[wr_addr_i] = new_valid;
      mask_d[wr_addr_i]  = new_valid && (new_t != '0);
      count_d = count_q + CntW'(ctl_i.set_valid) - CntW'(ctl_i.clr_valid);
      // swap the entry's old contribution for its new one
      gsum_d  = gsum_q - GsumW'(old_t) + GsumW'(new_t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      mask_q  <= '0;
      count_q <= '0;
      gsum_q  <= '0;
    end else begin
      valid_q <= valid_d;
      mask_q  <= mask_d;
      count_q <= count_d;
      gsum_q  <= gsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i && ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (commit_i && ctl_i.wr_en && wr_addr_i == rd_addr_i) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;
  assign valid_q_o = valid_q;
  assign count_q_o = count_q;
  assign valid_d_o = valid_d;
  assign count_d_o = count_d;
  assign mask_d_o  = mask_d;
  assign gsum_d_o  = gsum_d;

endmodule

### rtl/logical_channel_buffer_table.sv
// Logical channel buffer table of one channel group: accepts one beat per
// cycle unless stalled. The entry addressed by a beat is read from the
// backlog memory at the edge that accepts the beat, then updated and
// written back at the edge that commits it. The result is registered at
// that same edge. The input stalls only while a result waits unread in
// the result register and another beat already holds the update stage.
// Presence is kept in valid bits, so no clearing pass follows reset.
// Depends on lcbt_pkg, lcbt_update and lcbt_table.
module logical_channel_buffer_table #(
  parameter int unsigned NumChannels = lcbt_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lcbt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lcbt_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int unsigned CntW = $clog2(NumChannels + 1);
  localparam int unsigned GsumW = lcbt_pkg::TOTAL_W + $clog2(NumChannels);

  logic                uplink_q;
  logic                s1_valid_q;
  lcbt_pkg::in_item_t  s1_item_q;
  logic [IdxW-1:0]     s1_addr_q;
  logic                res_valid_q;
  lcbt_pkg::out_item_t res_q;

  logic                accept, commit;
  logic [IdxW-1:0]     only_idx, rd_addr, lc_idx;
  logic                inr, here, here_after;

  lcbt_pkg::entry_t    rd_data, new_entry;
  lcbt_pkg::upd_ctl_t  ctl;
  lcbt_pkg::err_e      err;
  logic [NumChannels-1:0] valid_q, valid_d, mask_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [GsumW-1:0]    gsum_d;

  assign cfg_ready_o = 1'b1;
  assign commit      = s1_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || commit;
  assign accept      = in_valid_i && in_ready_o;

  // index of the single present channel, valid when the count is one
  always_comb begin
    only_idx = '0;
    for (int i = 0; i < NumChannels; i++) begin
      if (valid_d[i]) begin
        only_idx = only_idx | IdxW'(i);
      end
    end
    if (in_data_i.mode == lcbt_pkg::MODE_GROUP_REPORT && count_d == CntW'(1)) begin
      rd_addr = only_idx;
    end else begin
      rd_addr = IdxW'(in_data_i.lc_id);
    end
  end

  always_comb begin
    lc_idx     = IdxW'(s1_item_q.lc_id);
    inr        = 32'(s1_item_q.lc_id) < 32'(NumChannels);
    here       = inr && valid_q[lc_idx];
    here_after = inr && valid_d[lc_idx];
  end

  lcbt_update u_update (
    .in_item_i   (s1_item_q),
    .old_i       (rd_data),
    .inr_i       (inr),
    .here_i      (here),
    .count_one_i (count_q == CntW'(1)),
    .uplink_i    (uplink_q),
    .ctl_o       (ctl),
    .err_o       (err),
    .new_o       (new_entry)
  );

  lcbt_table #(
    .NumChannels (NumChannels),
    .IdxW        (IdxW),
    .CntW        (CntW),
    .GsumW       (GsumW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .commit_i  (commit),
    .ctl_i     (ctl),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_entry),
    .rd_data_o (rd_data),
    .valid_q_o (valid_q),
    .count_q_o (count_q),
    .valid_d_o (valid_d),
    .count_d_o (count_d),
    .mask_d_o  (mask_d),
    .gsum_d_o  (gsum_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uplink_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        uplink_q <= cfg_data_i;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
      s1_addr_q <= rd_addr;
    end
    if (commit) begin
      res_q.error_code        <= err;
      res_q.lc_present        <= here_after;
      res_q.lc_total_bytes    <= here_after ?
        lcbt_pkg::sat32(lcbt_pkg::entry_total(ctl.wr_en ? new_entry : rd_data)) : 32'd0;
      res_q.group_total_bytes <= (gsum_d > GsumW'(lcbt_pkg::MAX32)) ?
        lcbt_pkg::MAX32 : gsum_d[31:0];
      res_q.active_mask       <= 32'(mask_d);
      res_q.channel_count     <= 6'(count_d);
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule
